@@ hw/rtl/lkvc_pkg.sv @@
// lkvc_pkg: sizes, codes and cell control types for the lru key-value cache
// no dependencies; used by the interfaces, the cell row and the top level
`timescale 1ns / 1ps

package lkvc_pkg;

   localparam int ENTRIES = 16;
   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;
   localparam int CAP_W   = 5;
   localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W   = $clog2(ENTRIES + 1);
   localparam int WIDE_W  = (CAP_W > OCC_W) ? CAP_W : OCC_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   // broadcast to every cell of the row
   typedef struct packed {
      logic              apply;
      logic              touch;
      logic              put_hit;
      logic              insert;
      logic              evict;
      logic [RANK_W-1:0] hit_rank;
      logic [RANK_W-1:0] victim_rank;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
   } cell_cmd_type;

   // what one cell reports back
   typedef struct packed {
      logic              match;
      logic [RANK_W-1:0] rank;
      logic [VAL_W-1:0]  value;
   } cell_stat_type;

endpackage

@@ hw/rtl/lkvc_ifs.sv @@
// lkvc request and response channel interfaces, valid/ready handshake
// depends on lkvc_pkg
`timescale 1ns / 1ps

interface lkvc_req_if;
   logic                              valid;
   logic                              ready;
   logic                              func;
   logic signed [lkvc_pkg::KEY_W-1:0] key;
   logic signed [lkvc_pkg::VAL_W-1:0] value;

   modport source (output valid, output func, output key, output value, input ready);
   modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface lkvc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              hit;
   logic signed [lkvc_pkg::VAL_W-1:0] value_out;

   modport source (output valid, output hit, output value_out, input ready);
   modport sink   (input valid, input hit, input value_out, output ready);
endinterface

@@ hw/rtl/lkvc_cell.sv @@
// lkvc_cell: one cache slot with key, value, valid bit and recency rank
// depends on lkvc_pkg; instantiated in a chain by lkvc_row
`timescale 1ns / 1ps

module lkvc_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  lkvc_pkg::cell_cmd_type  cmd,
   input  logic                    sel_in,
   input  logic                    chain_in,
   output logic                    chain_out,
   output lkvc_pkg::cell_stat_type stat
);

   logic [lkvc_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [lkvc_pkg::VAL_W-1:0]  value_ff, value_in;
   logic                        valid_ff, valid_in;
   logic [lkvc_pkg::RANK_W-1:0] rank_ff, rank_in;
   logic                        evict_me;
   logic                        free_here;
   logic                        take;

   assign evict_me  = cmd.evict && valid_ff && (rank_ff == cmd.victim_rank);
   assign free_here = !valid_ff || evict_me;
   // lowest free slot claims the new item
   assign take      = cmd.insert && free_here && !chain_in;
   assign chain_out = chain_in || free_here;

   assign stat.match = valid_ff && (key_ff == cmd.key);
   assign stat.rank  = rank_ff;
   assign stat.value = value_ff;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (cmd.apply) begin
         if (cmd.touch) begin
            if (sel_in) begin
               rank_in = '0;
               if (cmd.put_hit) begin
                  value_in = cmd.value;
               end
            end else if (valid_ff && (rank_ff < cmd.hit_rank)) begin
               rank_in = rank_ff + 1'b1;
            end
         end else if (cmd.insert) begin
            if (take) begin
               key_in   = cmd.key;
               value_in = cmd.value;
               valid_in = 1'b1;
               rank_in  = '0;
            end else if (evict_me) begin
               valid_in = 1'b0;
               rank_in  = '0;
            end else if (valid_ff) begin
               rank_in = rank_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

endmodule

@@ hw/rtl/lkvc_row.sv @@
// lkvc_row: chain of lkvc_cell slots with the free-slot chain between neighbors
// depends on lkvc_pkg and lkvc_cell
`timescale 1ns / 1ps

module lkvc_row (
   input  logic                                clock,
   input  logic                                reset,
   input  lkvc_pkg::cell_cmd_type              cmd,
   input  logic [lkvc_pkg::ENTRIES-1:0]        sel_vec,
   output logic [lkvc_pkg::ENTRIES-1:0]        match_vec,
   output logic [lkvc_pkg::VAL_W-1:0]          hit_value,
   output logic [lkvc_pkg::RANK_W-1:0]         hit_rank
);

   logic [lkvc_pkg::ENTRIES:0]  chain;
   lkvc_pkg::cell_stat_type     stat [lkvc_pkg::ENTRIES];

   assign chain[0] = 1'b0;

   for (genvar i = 0; i < lkvc_pkg::ENTRIES; i++) begin : g_cell
      lkvc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .sel_in    (sel_vec[i]),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1]),
         .stat      (stat[i])
      );
      assign match_vec[i] = stat[i].match;
   end

   // keys are unique among valid slots, so at most one term is live
   always_comb begin
      hit_value = '0;
      hit_rank  = '0;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         hit_value = hit_value | (stat[i].match ? stat[i].value : '0);
         hit_rank  = hit_rank  | (stat[i].match ? stat[i].rank  : '0);
      end
   end

endmodule

@@ hw/rtl/lru_key_value_cache.sv @@
// lru_key_value_cache: fully associative key-value cache, lru replacement
// depends on lkvc_pkg, lkvc_ifs and lkvc_row
//
//   channel   dir   handshake        payload
//   req_ch    in    valid / ready    func, key, value
//   rsp_ch    out   valid / ready    hit, value_out
//   csr_*     in    csr_wr_en        csr_wr_data (capacity)
//
// each item goes through accept, associative compare over the cell row,
// then the row update with the free-slot chain; one item is in work at a time
// the next item is accepted while the previous result waits in the rsp register
// the update cycle holds while that register is still full and rsp_ch is stalled
// synchronous reset clears all valid bits, ranks and occupancy; capacity is 16
`timescale 1ns / 1ps

module lru_key_value_cache (
   input  logic                        clock,
   input  logic                        reset,
   lkvc_req_if.sink                    req_ch,
   lkvc_rsp_if.source                  rsp_ch,
   input  logic                        csr_wr_en,
   input  logic [lkvc_pkg::CAP_W-1:0]  csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOOK = 3'b010,
      ST_UPD  = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic [lkvc_pkg::CAP_W-1:0]    cap_ff;
   logic [lkvc_pkg::OCC_W-1:0]    occ_ff, occ_in;
   logic                          func_ff;
   logic [lkvc_pkg::KEY_W-1:0]    key_ff;
   logic [lkvc_pkg::VAL_W-1:0]    value_ff;
   logic [lkvc_pkg::ENTRIES-1:0]  hit_vec_ff;
   logic                          hit_ff;
   logic [lkvc_pkg::VAL_W-1:0]    hit_value_ff;
   logic [lkvc_pkg::RANK_W-1:0]   hit_rank_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_hit_ff;
   logic [lkvc_pkg::VAL_W-1:0]    rsp_value_ff;

   logic                          req_fire;
   logic                          out_free;
   logic [lkvc_pkg::ENTRIES-1:0]  match_vec;
   logic [lkvc_pkg::VAL_W-1:0]    hit_value;
   logic [lkvc_pkg::RANK_W-1:0]   hit_rank;
   logic [lkvc_pkg::WIDE_W-1:0]   cap_wide;
   logic [lkvc_pkg::WIDE_W-1:0]   eff_cap;
   logic [lkvc_pkg::OCC_W-1:0]    occ_m1;
   logic                          insert;
   logic                          evict;
   lkvc_pkg::cell_cmd_type        cmd;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // capacity zero acts as one, above the built size as the built size
   assign cap_wide = lkvc_pkg::WIDE_W'(cap_ff);
   always_comb begin
      eff_cap = cap_wide;
      if (cap_wide == '0) begin
         eff_cap = lkvc_pkg::WIDE_W'(1);
      end else if (cap_wide > lkvc_pkg::WIDE_W'(lkvc_pkg::ENTRIES)) begin
         eff_cap = lkvc_pkg::WIDE_W'(lkvc_pkg::ENTRIES);
      end
   end

   assign occ_m1 = occ_ff - lkvc_pkg::OCC_W'(1);
   assign insert = !hit_ff && (func_ff == lkvc_pkg::FUNC_PUT);
   assign evict  = insert && (lkvc_pkg::WIDE_W'(occ_ff) >= eff_cap);

   always_comb begin
      cmd.apply       = (state_ff == ST_UPD) && out_free;
      cmd.touch       = hit_ff;
      cmd.put_hit     = hit_ff && (func_ff == lkvc_pkg::FUNC_PUT);
      cmd.insert      = insert;
      cmd.evict       = evict;
      cmd.hit_rank    = hit_rank_ff;
      cmd.victim_rank = occ_m1[lkvc_pkg::RANK_W-1:0];
      cmd.key         = key_ff;
      cmd.value       = value_ff;
   end

   lkvc_row u_row (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sel_vec   (hit_vec_ff),
      .match_vec (match_vec),
      .hit_value (hit_value),
      .hit_rank  (hit_rank)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      occ_in = occ_ff;
      if (cmd.apply && insert && !evict) begin
         occ_in = occ_ff + lkvc_pkg::OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff  <= req_ch.func;
         key_ff   <= req_ch.key;
         value_ff <= req_ch.value;
      end
      if (state_ff == ST_LOOK) begin
         hit_vec_ff   <= match_vec;
         hit_ff       <= |match_vec;
         hit_value_ff <= hit_value;
         hit_rank_ff  <= hit_rank;
      end
      if (cmd.apply) begin
         rsp_hit_ff   <= hit_ff;
         rsp_value_ff <= (hit_ff && (func_ff == lkvc_pkg::FUNC_GET)) ? hit_value_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= lkvc_pkg::CAP_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (cmd.apply) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.hit       = rsp_hit_ff;
   assign rsp_ch.value_out = rsp_value_ff;

   a_one_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) |-> $onehot0(match_vec))
      else $error("more than one slot holds the key");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= lkvc_pkg::OCC_W'(lkvc_pkg::ENTRIES))
      else $error("occupancy above built size");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> (rsp_value_ff == '0))
      else $error("miss result carries a value");

   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_LOOK))
      else $error("accepted item did not start the lookup");

endmodule

@@ verif/lru_key_value_cache_tb.sv @@
// lru_key_value_cache_tb: checks the lru key-value cache against a cycle-free lru cache model
// depends on lkvc_pkg, lkvc_ifs and lru_key_value_cache
// directed gets and puts on edge keys, then random item streams at several capacities
`timescale 1ns / 1ps

module lru_key_value_cache_tb;

   typedef struct {
      logic                       func;
      logic [lkvc_pkg::KEY_W-1:0] key;
      logic [lkvc_pkg::VAL_W-1:0] value;
   } request_type;

   typedef struct {
      logic                       hit;
      logic [lkvc_pkg::VAL_W-1:0] value_out;
   } reply_type;

   localparam int HOLD_AT   = 150;
   localparam int HOLD_LEN  = 60;
   localparam int SEG_ITEMS = 100;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_func    = lkvc_pkg::FUNC_GET;
   logic [lkvc_pkg::KEY_W-1:0] req_key     = '0;
   logic [lkvc_pkg::VAL_W-1:0] req_value   = '0;
   logic                       rsp_rdy     = 1'b0;
   logic                       csr_wr_en   = 1'b0;
   logic [lkvc_pkg::CAP_W-1:0] csr_wr_data = '0;

   // lru model state
   logic [lkvc_pkg::KEY_W-1:0] line_key[lkvc_pkg::ENTRIES];
   logic [lkvc_pkg::VAL_W-1:0] line_value[lkvc_pkg::ENTRIES];
   bit                         line_valid[lkvc_pkg::ENTRIES];
   int unsigned                line_age[lkvc_pkg::ENTRIES];
   int unsigned                lines_used;
   logic [lkvc_pkg::CAP_W-1:0] capacity_reg;

   request_type pending_reqs[$];
   reply_type   replies_due[$];
   bit          req_took     = 1'b0;
   int          replies_seen = 0;
   int          mismatches   = 0;
   int          idle_pct     = 0;
   int          req_gap      = 0;
   int          rsp_gap      = 0;
   int          hold_left    = 0;
   bit          hold_done    = 1'b0;

   lkvc_req_if req_ch();
   lkvc_rsp_if rsp_ch();

   assign req_ch.valid = req_valid;
   assign req_ch.func  = req_func;
   assign req_ch.key   = req_key;
   assign req_ch.value = req_value;
   assign rsp_ch.ready = rsp_rdy;

   lru_key_value_cache dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void make_newest(int s);
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
         if (line_valid[i] && i != s && line_age[i] < line_age[s])
            line_age[i]++;
      line_age[s] = 0;
   endfunction

   function automatic reply_type cache_access(request_type rq);
      reply_type   r;
      int          found;
      int          victim;
      int          slot;
      int unsigned limit;
      r.hit       = 1'b0;
      r.value_out = '0;
      found       = -1;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
         if (found < 0 && line_valid[i] && line_key[i] == rq.key)
            found = i;
      if (found >= 0) begin
         r.hit = 1'b1;
         if (rq.func == lkvc_pkg::FUNC_GET) begin
            r.value_out = line_value[found];
         end else begin
            line_value[found] = rq.value;
         end
         make_newest(found);
      end else if (rq.func == lkvc_pkg::FUNC_PUT) begin
         limit = (capacity_reg == 0) ? 1 :
                 ((capacity_reg > lkvc_pkg::ENTRIES) ? lkvc_pkg::ENTRIES : capacity_reg);
         if (lines_used >= limit) begin
            victim = -1;
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
               if (line_valid[i] && (victim < 0 || line_age[i] > line_age[victim]))
                  victim = i;
            if (victim >= 0) begin
               line_valid[victim] = 1'b0;
               line_age[victim]   = 0;
               lines_used--;
            end
         end
         slot = -1;
         for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
            if (slot < 0 && !line_valid[i])
               slot = i;
         if (slot >= 0) begin
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
               if (line_valid[i])
                  line_age[i]++;
            line_key[slot]   = rq.key;
            line_value[slot] = rq.value;
            line_valid[slot] = 1'b1;
            line_age[slot]   = 0;
            lines_used++;
         end
      end
      return r;
   endfunction

   // monitor: model update on accepted items, reply check
   always @(posedge clock) begin
      reply_type   want;
      request_type rq;
      if (reset) begin
         for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            line_valid[i] = 1'b0;
            line_age[i]   = 0;
         end
         lines_used   = 0;
         capacity_reg = lkvc_pkg::CAP_RESET;
         req_took     = 1'b0;
      end else begin
         if (csr_wr_en)
            capacity_reg = csr_wr_data;
         if (rsp_ch.valid && rsp_rdy) begin
            replies_seen++;
            if (replies_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected reply, hit %0b value_out %h",
                        $time, rsp_ch.hit, rsp_ch.value_out);
            end else begin
               want = replies_due.pop_front();
               if (rsp_ch.hit !== want.hit) begin
                  mismatches++;
                  $display("%0t: hit mismatch, expected %0b actual %0b",
                           $time, want.hit, rsp_ch.hit);
               end
               if (rsp_ch.value_out !== want.value_out) begin
                  mismatches++;
                  $display("%0t: value_out mismatch, expected %h actual %h",
                           $time, want.value_out, rsp_ch.value_out);
               end
            end
         end
         req_took = req_valid && req_ch.ready;
         if (req_took) begin
            rq.func  = req_func;
            rq.key   = req_key;
            rq.value = req_value;
            replies_due.push_back(cache_access(rq));
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      request_type rq;
      if (!reset && (!req_valid || req_took)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0 && $urandom_range(0, 99) < idle_pct) begin
            req_gap = $urandom_range(0, 5);
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            rq = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_func  <= rq.func;
            req_key   <= rq.key;
            req_value <= rq.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // reply side ready, with one long hold-off so the input backs up
   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && replies_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_rdy <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_rdy <= 1'b0;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            rsp_gap = $urandom_range(0, 5);
            rsp_rdy <= 1'b0;
         end else begin
            rsp_rdy <= 1'b1;
         end
      end
   end

   task automatic queue_req(logic func, logic [lkvc_pkg::KEY_W-1:0] key,
                            logic [lkvc_pkg::VAL_W-1:0] value);
      request_type rq;
      rq.func  = func;
      rq.key   = key;
      rq.value = value;
      pending_reqs.push_back(rq);
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_valid || replies_due.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [lkvc_pkg::CAP_W-1:0] cap);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = cap;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   initial begin
      int unsigned                seg_cap[8];
      int unsigned                cap;
      int unsigned                eff;
      int unsigned                pool_n;
      int unsigned                pick;
      logic [lkvc_pkg::KEY_W-1:0] key_pool[32];
      logic [lkvc_pkg::KEY_W-1:0] k;
      logic                       fn;
      seg_cap = '{5, 1, 16, 0, 31, 0, 3, 12};
      for (int i = 0; i < 32; i++)
         key_pool[i] = $urandom;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // edge keys and values at the reset capacity
      idle_pct = 20;
      queue_req(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'hffff_ffff);
      queue_req(lkvc_pkg::FUNC_PUT, 32'h8000_0000, 32'h7fff_ffff);
      queue_req(lkvc_pkg::FUNC_PUT, 32'h7fff_ffff, 32'h8000_0000);
      queue_req(lkvc_pkg::FUNC_PUT, 32'h0000_0000, 32'h0000_0000);
      queue_req(lkvc_pkg::FUNC_PUT, 32'hffff_ffff, 32'hffff_ffff);
      queue_req(lkvc_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000);
      queue_req(lkvc_pkg::FUNC_GET, 32'h7fff_ffff, 32'h0000_0000);
      queue_req(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'h5a5a_5a5a);
      queue_req(lkvc_pkg::FUNC_GET, 32'hffff_ffff, 32'h0000_0000);
      queue_req(lkvc_pkg::FUNC_PUT, 32'h8000_0000, 32'h0000_0001);
      queue_req(lkvc_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000);
      queue_req(lkvc_pkg::FUNC_GET, 32'h8000_0001, 32'h0000_0000);
      wait_idle();

      // capacity below occupancy: each insert evicts one, occupancy holds
      write_capacity(lkvc_pkg::CAP_W'(2));
      queue_req(lkvc_pkg::FUNC_PUT, 32'h1234_5678, 32'hdead_beef);
      queue_req(lkvc_pkg::FUNC_GET, 32'h7fff_ffff, 32'h0000_0000);
      queue_req(lkvc_pkg::FUNC_GET, 32'h1234_5678, 32'h0000_0000);
      wait_idle();

      // zero capacity acts as one
      write_capacity(lkvc_pkg::CAP_W'(0));
      queue_req(lkvc_pkg::FUNC_PUT, 32'h0000_0001, 32'h0000_0002);
      queue_req(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
      queue_req(lkvc_pkg::FUNC_GET, 32'h0000_0001, 32'h0000_0000);
      wait_idle();

      // capacity above the built size acts as the built size
      write_capacity(lkvc_pkg::CAP_W'(31));
      queue_req(lkvc_pkg::FUNC_PUT, 32'h0000_0010, 32'h0000_0011);
      queue_req(lkvc_pkg::FUNC_PUT, 32'h0000_0020, 32'h0000_0021);
      queue_req(lkvc_pkg::FUNC_PUT, 32'h0000_0030, 32'h0000_0031);
      queue_req(lkvc_pkg::FUNC_GET, 32'h0000_0020, 32'h0000_0000);

      for (int s = 0; s < 8; s++) begin
         wait_idle();
         cap = (s == 5) ? $urandom_range(2, 15) : seg_cap[s];
         write_capacity(lkvc_pkg::CAP_W'(cap));
         eff    = (cap == 0) ? 1 : ((cap > lkvc_pkg::ENTRIES) ? lkvc_pkg::ENTRIES : cap);
         pool_n = eff + $urandom_range(1, 8);
         if (pool_n > 32)
            pool_n = 32;
         idle_pct = (s >= 6) ? 0 : 15 * $urandom_range(0, 2);
         for (int n = 0; n < SEG_ITEMS; n++) begin
            if ($urandom_range(0, 19) == 0)
               key_pool[$urandom_range(0, 31)] = $urandom;
            pick = $urandom_range(0, 9);
            k    = key_pool[$urandom_range(0, pool_n - 1)];
            if (pick == 0) begin
               k = $urandom;
            end else if (pick == 1) begin
               k[$urandom_range(0, lkvc_pkg::KEY_W - 1)] ^= 1'b1;
            end
            fn = $urandom_range(0, 1) ? lkvc_pkg::FUNC_PUT : lkvc_pkg::FUNC_GET;
            queue_req(fn, k, $urandom);
         end
      end

      wait_idle();
      if (mismatches == 0 && replies_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
